// ===== rtl/rsq_pkg.sv =====
`timescale 1ns / 1ps

package rsq_pkg;

    localparam int ID_W           = 16;
    localparam int ID_SPACE       = 65536;
    localparam int CNT_W          = 32;
    localparam int DEF_MAX_PERIOD = 32768;
    localparam int MIN_PERIOD     = 512;
    localparam int DEF_PERIOD     = 8192;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic commit;
        logic unmark;
        logic clr_step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cand_zero;
        logic hit;
        logic need_unmark;
        logic out_free;
        logic clr_last;
        logic cfg_hit;
    } t_sts;

endpackage

// ===== rtl/rsq_ctrl.sv =====
`timescale 1ns / 1ps

module rsq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  rsq_pkg::t_sts i_sts,
    output rsq_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_UNMARK
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_issue;

    assign w_issue = !i_sts.cand_zero && !i_sts.hit;

    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.commit    = (r_state == S_LOOKUP) && i_sts.out_free;
        o_cmd.unmark    = (r_state == S_UNMARK);
        o_cmd.clr_step  = (r_state == S_CLEAR);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (i_sts.out_free) begin
                    n_state = (w_issue && i_sts.need_unmark) ? S_UNMARK : S_IDLE;
                end
            end
            S_UNMARK: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        if (i_sts.cfg_hit) begin
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_sts.cfg_hit) |=> (r_state == S_LOOKUP))
        else $error("accepted beat did not start a lookup");

    a_unmark_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UNMARK && !i_sts.cfg_hit) |=> (r_state == S_IDLE))
        else $error("unmark step longer than one cycle");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.cfg_hit |=> (r_state == S_CLEAR))
        else $error("period write did not start the clearing pass");

endmodule

// ===== rtl/rsq_dp.sv =====
`timescale 1ns / 1ps

module rsq_dp #(
    parameter int MAX_PERIOD = rsq_pkg::DEF_MAX_PERIOD
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rsq_pkg::t_cmd             i_cmd,
    output rsq_pkg::t_sts             o_sts,
    input  logic [rsq_pkg::ID_W-1:0]  i_candidate,
    input  logic                      i_cfg_valid,
    input  logic [rsq_pkg::ID_W-1:0]  i_cfg_period,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic                      o_accepted,
    output logic [rsq_pkg::ID_W-1:0]  o_issued_id,
    output logic [rsq_pkg::CNT_W-1:0] o_collision_count,
    output logic [rsq_pkg::CNT_W-1:0] o_issued_count
);

    localparam int PW = $clog2(MAX_PERIOD);
    localparam int XW = rsq_pkg::ID_W + 1;
    localparam int RESET_PERIOD = (rsq_pkg::DEF_PERIOD > MAX_PERIOD) ?
                                  MAX_PERIOD : rsq_pkg::DEF_PERIOD;

    // id store and used map
    logic [rsq_pkg::ID_W-1:0] r_ring [0:MAX_PERIOD-1];
    logic                     r_used_map [0:rsq_pkg::ID_SPACE-1];

    logic [rsq_pkg::ID_W-1:0]  r_period;
    logic [PW-1:0]             r_pos;
    logic                      r_wrapped;
    logic [rsq_pkg::ID_W-1:0]  r_cand;
    logic [rsq_pkg::ID_W-1:0]  r_old;
    logic [rsq_pkg::ID_W-1:0]  r_ring_rd;
    logic                      r_map_rd;
    logic [rsq_pkg::ID_W-1:0]  r_clr_addr;
    logic [rsq_pkg::CNT_W-1:0] r_coll;
    logic [rsq_pkg::CNT_W-1:0] r_issued;
    logic                      r_out_valid;
    logic                      r_accepted;
    logic [rsq_pkg::ID_W-1:0]  r_issued_id;

    logic                     w_cfg_hit;
    logic                     w_cand_zero;
    logic                     w_issue;
    logic [PW:0]              w_pos_inc;
    logic                     w_wrap;
    logic [rsq_pkg::ID_W-1:0] w_map_ra;
    logic                     w_map_we;
    logic [rsq_pkg::ID_W-1:0] w_map_wa;
    logic                     w_map_wd;
    logic                     w_out_free;

    assign w_cfg_hit   = i_cfg_valid
                      && (i_cfg_period >= rsq_pkg::ID_W'(rsq_pkg::MIN_PERIOD))
                      && ({1'b0, i_cfg_period} <= XW'(MAX_PERIOD));
    assign w_cand_zero = (r_cand == '0);
    assign w_issue     = !w_cand_zero && !r_map_rd;
    assign w_pos_inc   = {1'b0, r_pos} + (PW+1)'(1);
    assign w_wrap      = (XW'(w_pos_inc) >= {1'b0, r_period});
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_map_ra    = i_cmd.load ? i_candidate : r_cand;

    always_comb begin
        o_sts.cand_zero   = w_cand_zero;
        o_sts.hit         = r_map_rd;
        o_sts.need_unmark = r_wrapped && (r_ring_rd != '0);
        o_sts.out_free    = w_out_free;
        o_sts.clr_last    = (r_clr_addr == '1);
        o_sts.cfg_hit     = w_cfg_hit;
    end

    // map write port select
    always_comb begin
        w_map_we = 1'b0;
        w_map_wa = r_cand;
        w_map_wd = 1'b0;
        if (i_cmd.clr_step) begin
            w_map_we = 1'b1;
            w_map_wa = r_clr_addr;
        end else if (i_cmd.commit && w_issue) begin
            w_map_we = 1'b1;
            w_map_wd = 1'b1;
        end else if (i_cmd.unmark) begin
            w_map_we = 1'b1;
            w_map_wa = r_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            r_used_map[w_map_wa] <= w_map_wd;
        end
        r_map_rd <= r_used_map[w_map_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_issue) begin
            r_ring[r_pos] <= r_cand;
        end
        r_ring_rd <= r_ring[r_pos];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cand <= i_candidate;
        end
        if (i_cmd.commit) begin
            r_old       <= r_ring_rd;
            r_accepted  <= w_issue;
            r_issued_id <= w_issue ? r_cand : '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= rsq_pkg::ID_W'(RESET_PERIOD);
            r_pos       <= '0;
            r_wrapped   <= 1'b0;
            r_clr_addr  <= '0;
            r_coll      <= '0;
            r_issued    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + rsq_pkg::ID_W'(1);
            end
            if (i_cmd.commit && !w_cand_zero) begin
                if (r_map_rd) begin
                    r_coll <= r_coll + rsq_pkg::CNT_W'(1);
                end else begin
                    r_issued <= r_issued + rsq_pkg::CNT_W'(1);
                    if (w_wrap) begin
                        r_pos     <= '0;
                        r_wrapped <= 1'b1;
                    end else begin
                        r_pos <= w_pos_inc[PW-1:0];
                    end
                end
            end
            if (w_cfg_hit) begin
                r_period   <= i_cfg_period;
                r_pos      <= '0;
                r_wrapped  <= 1'b0;
                r_clr_addr <= '0;
                r_coll     <= '0;
                r_issued   <= '0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_accepted;
    assign o_issued_id       = r_issued_id;
    assign o_collision_count = r_coll;
    assign o_issued_count    = r_issued;

    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a waiting beat");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (XW'(r_pos) < {1'b0, r_period}))
        else $error("ring position beyond period");

    a_unmark_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.unmark |-> (r_wrapped && (r_old != '0)))
        else $error("unmark of an id never stored");

endmodule

// ===== rtl/random_id_searchable_queue.sv =====
`timescale 1ns / 1ps

// channel  signals                                        direction
// in       i_in_valid, o_in_ready, i_candidate            beat in
// out      o_out_valid, i_out_ready, o_accepted,          beat out
//          o_issued_id, o_collision_count, o_issued_count
// cfg      i_cfg_valid, o_cfg_ready, i_cfg_period         write in
//
// each candidate goes through a map and ring read, then a commit, and an
// unmark step when an old id leaves the ring, as the used map has a single write port
// after reset and after each accepted period write the used map is cleared
// one entry a cycle over the whole id space, with o_in_ready low
// a result waits in the output register; the lookup holds until it is taken
// an out-of-range period write is ignored

module random_id_searchable_queue #(
    parameter int MAX_PERIOD = rsq_pkg::DEF_MAX_PERIOD
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [rsq_pkg::ID_W-1:0]  i_candidate,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_accepted,
    output logic [rsq_pkg::ID_W-1:0]  o_issued_id,
    output logic [rsq_pkg::CNT_W-1:0] o_collision_count,
    output logic [rsq_pkg::CNT_W-1:0] o_issued_count,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [rsq_pkg::ID_W-1:0]  i_cfg_period
);

    rsq_pkg::t_cmd w_cmd;
    rsq_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    rsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    rsq_dp #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_candidate       (i_candidate),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_period      (i_cfg_period),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_accepted        (o_accepted),
        .o_issued_id       (o_issued_id),
        .o_collision_count (o_collision_count),
        .o_issued_count    (o_issued_count)
    );

endmodule
